// ----- design/pwl_pkg.sv -----
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants for the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam int KIND_W     = 2;
    localparam int IDX_W      = 3;
    localparam int PTS_W      = 4;
    localparam int MIN_POINTS = 2;

    localparam logic [PTS_W-1:0] PTS_RESET = 4'd8;

    // request kinds carried on tuser
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_A2P   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_P2A   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic prep;
        logic mul;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic item_conv;
        logic scan_done;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ----- design/pwl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pwl_ctrl
// Sequencer for the interpolator: accept, segment scan, operand prep,
// multiply, restoring divide and result hand-off.
// ----------------------------------------------------------------------------
module pwl_ctrl
    import pwl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no request is taken while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.accept = 1'b1;
                    // writes and unused kinds go straight to the result
                    state_next = sts.item_conv ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/pwl_dpath.sv -----
// ----------------------------------------------------------------------------
// pwl_dpath
// Breakpoint memory, segment scan registers, multiplier, restoring divider
// and the output register of the interpolator.
// ----------------------------------------------------------------------------
module pwl_dpath
    import pwl_pkg::*;
#(
    parameter int MAX_POINTS  = 8,
    parameter int VALUE_WIDTH = 16,
    parameter int IN_W        = 40,
    parameter int OUT_W       = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output status_t          sts,
    input  logic [IN_W-1:0]  s_data,
    input  logic [KIND_W-1:0] s_kind,
    input  logic             cfg_we,
    input  logic [PTS_W-1:0] cfg_wdata,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [OUT_W-1:0] m_data,
    output logic             m_flag
);

    localparam int VW = VALUE_WIDTH;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = $clog2(VALUE_WIDTH);

    // unpacked request fields
    logic [IDX_W-1:0]     in_idx;
    logic signed [VW-1:0] in_ang;
    logic signed [VW-1:0] in_pos;

    assign in_idx = s_data[IDX_W-1:0];
    assign in_ang = s_data[IDX_W +: VW];
    assign in_pos = s_data[IDX_W+VW +: VW];

    // breakpoint memory, one {position, angle} pair per entry
    logic [2*VW-1:0] mem [0:MAX_POINTS-1];
    logic [2*VW-1:0] rd_q_reg;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;

    // control state
    logic [PTS_W-1:0] pts_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DW-1:0]    div_cnt_reg;
    logic             match_reg;
    logic             out_valid_reg;

    // payload
    logic                 conv_reg;
    logic                 dir_reg;
    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] first_src_reg;
    logic signed [VW-1:0] first_dst_reg;
    logic signed [VW-1:0] prev_src_reg;
    logic signed [VW-1:0] prev_dst_reg;
    logic signed [VW-1:0] seg_lo_reg;
    logic signed [VW-1:0] seg_hi_reg;
    logic signed [VW-1:0] seg_dlo_reg;
    logic signed [VW-1:0] seg_dhi_reg;
    logic [VW-1:0]        da_reg;
    logic [VW-1:0]        dx_reg;
    logic [VW-1:0]        mag_reg;
    logic                 neg_reg;
    logic                 zw_reg;
    logic                 lo_clamp_reg;
    logic                 hi_clamp_reg;
    logic [2*VW-1:0]      div_reg;
    logic [VW-1:0]        res_reg;
    logic                 inr_reg;

    logic [CW-1:0]        n_used;
    logic signed [VW-1:0] cur_src;
    logic signed [VW-1:0] cur_dst;
    logic                 seg_hit;
    logic signed [VW:0]   da_w;
    logic signed [VW:0]   dx_w;
    logic signed [VW:0]   dp_w;
    logic signed [VW:0]   dp_abs;
    logic [2*VW-1:0]      prod;
    logic [VW:0]          div_t;
    logic [VW:0]          div_diff;
    logic                 div_ge;
    logic [VW-1:0]        div_hi_next;
    logic signed [VW:0]   interp;
    logic [VW-1:0]        res_next;
    logic                 inr_next;

    assign wr_en   = cmd.accept && (s_kind == KIND_WRITE)
                   && (32'(in_idx) < MAX_POINTS);
    assign rd_addr = cnt_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[AW'(in_idx)] <= {in_pos, in_ang};
        end
        rd_q_reg <= mem[rd_addr];
    end

    // point count as used, clamped to the table limits
    always_comb begin
        if (pts_reg < PTS_W'(MIN_POINTS)) begin
            n_used = CW'(MIN_POINTS);
        end else if (32'(pts_reg) > MAX_POINTS) begin
            n_used = CW'(MAX_POINTS);
        end else begin
            n_used = CW'(pts_reg);
        end
    end

    // entry read last cycle, as source and destination
    assign cur_src = dir_reg ? rd_q_reg[VW-1:0] : rd_q_reg[2*VW-1:VW];
    assign cur_dst = dir_reg ? rd_q_reg[2*VW-1:VW] : rd_q_reg[VW-1:0];
    assign seg_hit = (x_reg >= prev_src_reg) && (x_reg <= cur_src);

    assign da_w   = {seg_hi_reg[VW-1], seg_hi_reg} - {seg_lo_reg[VW-1], seg_lo_reg};
    assign dx_w   = {x_reg[VW-1], x_reg} - {seg_lo_reg[VW-1], seg_lo_reg};
    assign dp_w   = {seg_dhi_reg[VW-1], seg_dhi_reg} - {seg_dlo_reg[VW-1], seg_dlo_reg};
    assign dp_abs = dp_w[VW] ? -dp_w : dp_w;

    assign prod = (2*VW)'(mag_reg) * (2*VW)'(dx_reg);

    // one restoring divide step per cycle, quotient shifts into the low half
    assign div_t       = div_reg[2*VW-1:VW-1];
    assign div_diff    = div_t - {1'b0, da_reg};
    assign div_ge      = div_t >= {1'b0, da_reg};
    assign div_hi_next = div_ge ? div_diff[VW-1:0] : div_t[VW-1:0];

    assign interp = neg_reg ? ({seg_dlo_reg[VW-1], seg_dlo_reg} - {1'b0, div_reg[VW-1:0]})
                            : ({seg_dlo_reg[VW-1], seg_dlo_reg} + {1'b0, div_reg[VW-1:0]});

    always_comb begin
        priority if (!conv_reg) begin
            res_next = '0;
        end else if (lo_clamp_reg) begin
            res_next = first_dst_reg;
        end else if (hi_clamp_reg) begin
            res_next = prev_dst_reg;
        end else if (!match_reg) begin
            res_next = '0;
        end else if (zw_reg) begin
            res_next = seg_dlo_reg;
        end else begin
            res_next = interp[VW-1:0];
        end
    end

    assign inr_next = conv_reg && !lo_clamp_reg && !hi_clamp_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pts_reg       <= PTS_RESET;
            cnt_reg       <= '0;
            div_cnt_reg   <= '0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                pts_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                cnt_reg   <= '0;
                match_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                cnt_reg <= cnt_reg + CW'(1);
                if ((cnt_reg > CW'(1)) && seg_hit) begin
                    match_reg <= 1'b1;
                end
            end
            if (cmd.mul) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + DW'(1);
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x_reg    <= (s_kind == KIND_P2A) ? in_pos : in_ang;
            dir_reg  <= (s_kind == KIND_A2P);
            conv_reg <= (s_kind == KIND_A2P) || (s_kind == KIND_P2A);
        end
        if (cmd.scan_step && (cnt_reg != '0)) begin
            if (cnt_reg == CW'(1)) begin
                first_src_reg <= cur_src;
                first_dst_reg <= cur_dst;
            end else if (seg_hit) begin
                // later segments override earlier matches
                seg_lo_reg  <= prev_src_reg;
                seg_hi_reg  <= cur_src;
                seg_dlo_reg <= prev_dst_reg;
                seg_dhi_reg <= cur_dst;
            end
            prev_src_reg <= cur_src;
            prev_dst_reg <= cur_dst;
        end
        if (cmd.prep) begin
            da_reg       <= da_w[VW-1:0];
            dx_reg       <= dx_w[VW-1:0];
            mag_reg      <= dp_abs[VW-1:0];
            neg_reg      <= dp_w[VW];
            zw_reg       <= (seg_hi_reg == seg_lo_reg);
            lo_clamp_reg <= (x_reg < first_src_reg);
            hi_clamp_reg <= (x_reg > prev_src_reg);
        end
        if (cmd.mul) begin
            div_reg <= prod;
        end else if (cmd.div_step) begin
            div_reg <= {div_hi_next, div_reg[VW-2:0], div_ge};
        end
        if (cmd.load_out) begin
            res_reg <= res_next;
            inr_reg <= inr_next;
        end
    end

    assign sts.item_conv = (s_kind == KIND_A2P) || (s_kind == KIND_P2A);
    assign sts.scan_done = (cnt_reg == n_used);
    assign sts.div_last  = (div_cnt_reg == DW'(VALUE_WIDTH - 1));
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = OUT_W'(res_reg);
    assign m_flag  = inr_reg;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (cnt_reg <= n_used))
        else $error("scan counter ran past the point count");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("result valid without a load");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && !conv_reg) |=> ((res_reg == '0) && !inr_reg))
        else $error("write request returned a nonzero result");
`endif

endmodule

// ----- design/piecewise_linear_table_interp_top.sv -----
// Piecewise-linear lookup between a steering-angle table and an actuator-
// position table (signed Q8.8). A request with tuser 0 writes one breakpoint
// pair and returns zero; tuser 1 maps an angle to a position, tuser 2 a
// position to an angle. A conversion scans the N breakpoints in use through
// a breakpoint memory with a registered read port (one entry per cycle, last
// matching segment wins), then multiplies once and runs a one-bit-per-cycle
// restoring divide; no new request is accepted until its result is loaded
// into the output register. Out-of-table values clamp to the end entries
// with in_range low. Tables have no reset and must be written before use;
// points_in_use must be written only when idle; the block does not enforce it.

// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_top
    import pwl_pkg::*;
#(
    parameter int MAX_POINTS  = 8,
    parameter int VALUE_WIDTH = 16,
    localparam int IN_W  = ((IDX_W + 2 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // entry_index, angle_word, position_word (low to high), zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0] s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // result_value, zero pad
    output logic [OUT_W-1:0]  m_axis_tdata,
    // in_range
    output logic              m_axis_tuser,
    input  logic              cfg_we,
    input  logic [PTS_W-1:0]  cfg_wdata
);

    cmd_t    cmd;
    status_t sts;

    pwl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pwl_dpath #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_axis_tdata),
        .s_kind    (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_flag    (m_axis_tuser)
    );

endmodule

// ----- verif/piecewise_linear_table_interp_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top_tb
// Self-checking testbench for the breakpoint-table interpolator. It loads
// the angle and position tables and runs a directed table of requests. It
// then runs random phases under several point counts: table reloads, stray
// writes, unused kinds and conversions aimed at breakpoints and segments.
// Results are checked in order against an in-bench model or typed row values.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_top_tb;
    import pwl_pkg::*;

    localparam int MAX_PTS         = 8;
    localparam int VW              = 16;
    localparam int IN_W            = 40;
    localparam int NUM_DIR         = 24;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 111;
    localparam int SETTLE_CYCLES   = 40;
    localparam int LONG_HOLD       = 400;
    localparam int CYCLE_LIMIT     = 500000;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          in_range;
    } result_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [IDX_W-1:0]    idx;
        logic signed [VW-1:0] ang;
        logic signed [VW-1:0] pos;
        bit                  typed;
        result_t             exp;
    } stim_row_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // entry_index, angle_word, position_word (low to high), zero pad
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    // kind
    logic [KIND_W-1:0] s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // result_value
    logic [VW-1:0]     m_axis_tdata;
    // in_range
    logic              m_axis_tuser;
    logic              cfg_we        = 1'b0;
    logic [PTS_W-1:0]  cfg_wdata     = '0;

    // model state
    logic signed [VW-1:0] angle_tbl    [MAX_PTS];
    logic signed [VW-1:0] position_tbl [MAX_PTS];
    logic [PTS_W-1:0]     points_reg = PTS_RESET;

    result_t pending_results [$];
    result_t head;
    int      err_count   = 0;
    int      cycle_count = 0;
    bit      tx_idle_on  = 1'b1;
    bit      rx_idle_on  = 1'b1;
    bit      hold_long   = 1'b0;

    stim_row_t dir_rows [NUM_DIR] = '{
        '{KIND_WRITE,  3'd0, -16'sd20000, 16'sh8000,   1'b1, '{16'd0, 1'b0}},
        '{KIND_WRITE,  3'd1, -16'sd5120,  -16'sd10000, 1'b1, '{16'd0, 1'b0}},
        '{KIND_WRITE,  3'd2, -16'sd2560,  -16'sd2000,  1'b1, '{16'd0, 1'b0}},
        '{KIND_WRITE,  3'd3, 16'sd0,      16'sd100,    1'b1, '{16'd0, 1'b0}},
        '{KIND_WRITE,  3'd4, 16'sd0,      16'sd700,    1'b1, '{16'd0, 1'b0}},
        '{KIND_WRITE,  3'd5, 16'sd2560,   16'sd3000,   1'b1, '{16'd0, 1'b0}},
        '{KIND_WRITE,  3'd6, 16'sd5120,   16'sd32767,  1'b1, '{16'd0, 1'b0}},
        '{KIND_WRITE,  3'd7, 16'sd20000,  16'sd30000,  1'b1, '{16'd0, 1'b0}},
        '{KIND_UNUSED, 3'd7, 16'sd32767,  16'sh8000,   1'b1, '{16'd0, 1'b0}},
        // clamp below and above the table, then the first breakpoint
        '{KIND_A2P,    3'd0, 16'sh8000,   16'sd0,      1'b1, '{16'sh8000, 1'b0}},
        '{KIND_A2P,    3'd7, 16'sd32767,  16'sd32767,  1'b1, '{16'sd30000, 1'b0}},
        '{KIND_A2P,    3'd0, -16'sd20000, 16'sd0,      1'b1, '{16'sh8000, 1'b1}},
        // zero-width segment in the middle of the angle table
        '{KIND_A2P,    3'd0, 16'sd0,      16'sd0,      1'b0, '{16'd0, 1'b0}},
        '{KIND_A2P,    3'd0, 16'sd20000,  16'sd0,      1'b0, '{16'd0, 1'b0}},
        // falling segment of the position table
        '{KIND_A2P,    3'd0, 16'sd10000,  16'sd0,      1'b0, '{16'd0, 1'b0}},
        '{KIND_A2P,    3'd0, -16'sd3000,  16'sd0,      1'b0, '{16'd0, 1'b0}},
        '{KIND_P2A,    3'd0, 16'sd0,      16'sh8000,   1'b0, '{16'd0, 1'b0}},
        '{KIND_P2A,    3'd0, 16'sd0,      16'sd32767,  1'b0, '{16'd0, 1'b0}},
        '{KIND_P2A,    3'd0, 16'sd0,      16'sd500,    1'b0, '{16'd0, 1'b0}},
        '{KIND_P2A,    3'd0, 16'sd0,      16'sd31000,  1'b0, '{16'd0, 1'b0}},
        '{KIND_UNUSED, 3'd0, 16'sd0,      16'sd0,      1'b1, '{16'd0, 1'b0}},
        '{KIND_WRITE,  3'd7, 16'sd32767,  -16'sd1,     1'b1, '{16'd0, 1'b0}},
        '{KIND_A2P,    3'd0, 16'sd32767,  16'sd0,      1'b0, '{16'd0, 1'b0}},
        '{KIND_P2A,    3'd0, 16'sd0,      -16'sd1,     1'b0, '{16'd0, 1'b0}}
    };

    piecewise_linear_table_interp_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic result_t interp_lookup(input bit from_angle,
                                              input logic signed [VW-1:0] x);
        logic signed [VW-1:0] src [MAX_PTS];
        logic signed [VW-1:0] dst [MAX_PTS];
        int      n;
        longint  lo, hi, dlo, dhi, dp, mag, q, acc;
        result_t r;
        if (from_angle) begin
            src = angle_tbl;
            dst = position_tbl;
        end else begin
            src = position_tbl;
            dst = angle_tbl;
        end
        n = (points_reg < MIN_POINTS) ? MIN_POINTS :
            (points_reg > MAX_PTS) ? MAX_PTS : int'(points_reg);
        acc = 0;
        // every matching segment is evaluated, the last one wins
        for (int i = 0; i < n - 1; i++) begin
            lo  = src[i];
            hi  = src[i+1];
            dlo = dst[i];
            dhi = dst[i+1];
            if (x >= lo && x <= hi) begin
                if (hi == lo) begin
                    acc = dlo;
                end else begin
                    dp  = dhi - dlo;
                    mag = (dp < 0) ? -dp : dp;
                    q   = (mag * (x - lo)) / (hi - lo);
                    acc = (dp < 0) ? dlo - q : dlo + q;
                end
            end
        end
        r.in_range = 1'b1;
        if (x > src[n-1]) begin
            acc        = dst[n-1];
            r.in_range = 1'b0;
        end
        if (x < src[0]) begin
            acc        = dst[0];
            r.in_range = 1'b0;
        end
        r.value = acc[VW-1:0];
        return r;
    endfunction

    function automatic result_t process_request(input logic [KIND_W-1:0] kind,
                                                input logic [IDX_W-1:0] idx,
                                                input logic signed [VW-1:0] ang,
                                                input logic signed [VW-1:0] pos);
        result_t r;
        r = '0;
        case (kind)
            KIND_WRITE: begin
                angle_tbl[idx]    = ang;
                position_tbl[idx] = pos;
            end
            KIND_A2P: r = interp_lookup(1'b1, ang);
            KIND_P2A: r = interp_lookup(1'b0, pos);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [IDX_W-1:0] idx,
                                input logic signed [VW-1:0] ang,
                                input logic signed [VW-1:0] pos,
                                input bit typed, input result_t typed_exp);
        result_t r;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b0, pos, ang, idx};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        r = process_request(kind, idx, ang, pos);
        pending_results.push_back(typed ? typed_exp : r);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: result_value %0d in_range %0b",
                       $signed(m_axis_tdata), m_axis_tuser);
                err_count++;
            end else begin
                head = pending_results.pop_front();
                if (m_axis_tdata !== head.value) begin
                    $error("result_value mismatch: expected %0d, actual %0d",
                           $signed(head.value), $signed(m_axis_tdata));
                    err_count++;
                end
                if (m_axis_tuser !== head.in_range) begin
                    $error("in_range mismatch: expected %0b, actual %0b",
                           head.in_range, m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    // result-side backpressure
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_long) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_long = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [KIND_W-1:0]    kind;
        logic [IDX_W-1:0]     idx;
        logic signed [VW-1:0] ang, pos, x;
        logic [PTS_W-1:0]     pts;
        int                   pick, lo, hi, a_run, p_run, p_mode, step;
        int                   phase_pts [NUM_PHASES];

        phase_pts = '{2, 15, 0, 5, 8, 1, 3, 8};
        for (int i = 0; i < MAX_PTS; i++) begin
            angle_tbl[i]    = '0;
            position_tbl[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < NUM_DIR; r++) begin
            send_request(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].ang,
                         dir_rows[r].pos, dir_rows[r].typed, dir_rows[r].exp);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            pts = (ph == 6) ? PTS_W'($urandom_range(0, 15)) : PTS_W'(phase_pts[ph]);
            cfg_wdata <= pts;
            cfg_we    <= 1'b1;
            @(posedge aclk);
            cfg_we     <= 1'b0;
            points_reg = pts;
            @(posedge aclk);
            if (ph == NUM_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (ph == 0) hold_long = 1'b1;

            // fresh table: rising angles, position rising, falling or scattered
            if ($urandom_range(0, 9) < 6) begin
                a_run  = $urandom_range(0, 30000) - 32767;
                p_run  = $urandom_range(0, 30000) - 32767;
                p_mode = $urandom_range(0, 2);
                for (int i = 0; i < MAX_PTS; i++) begin
                    pos = (p_mode == 0) ? VW'(p_run) :
                          (p_mode == 1) ? VW'(-p_run) : VW'($urandom);
                    send_request(KIND_WRITE, IDX_W'(i), VW'(a_run), pos, 1'b0, '0);
                    step  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 9000);
                    a_run = (a_run + step > 32767) ? 32767 : a_run + step;
                    step  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 9000);
                    p_run = (p_run + step > 32767) ? 32767 : p_run + step;
                end
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                idx  = IDX_W'($urandom);
                ang  = VW'($urandom);
                pos  = VW'($urandom);
                if (pick < 8) begin
                    kind = KIND_WRITE;
                end else if (pick < 13) begin
                    kind = KIND_UNUSED;
                end else begin
                    kind = (pick % 2 == 0) ? KIND_A2P : KIND_P2A;
                    lo = (kind == KIND_A2P) ? angle_tbl[idx] : position_tbl[idx];
                    hi = (kind == KIND_A2P) ? angle_tbl[(idx == 7) ? 7 : idx + 1] :
                                              position_tbl[(idx == 7) ? 7 : idx + 1];
                    case ($urandom_range(0, 3))
                        0: x = VW'($urandom);
                        1, 2: x = VW'(lo + $urandom_range(0, 4) - 2);
                        default: x = VW'(lo + ($urandom_range(0, 1023) * (hi - lo)) / 1024);
                    endcase
                    if (kind == KIND_A2P) ang = x;
                    else pos = x;
                end
                send_request(kind, idx, ang, pos, 1'b0, '0);
            end
        end

        wait_drained();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
